// ----- rtl/core/pip_pkg.sv -----
// Shared types for the point-in-polygon crossing test.
package pip_pkg;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  // Per-word flags that travel down the pipeline with each vertex.
  typedef struct packed {
    logic first;
    logic last;
  } pip_flags_t;

endpackage

// ----- rtl/core/pip_if.sv -----
// Handshake interfaces for the vertex input and the inside-flag result.
interface pip_vertex_if #(
  parameter int W = 32
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] vertex_x;
  logic signed [W-1:0] vertex_y;
  logic signed [W-1:0] vertex_z;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;
  logic signed [W-1:0] point_z;
  logic signed [W-1:0] normal_x;
  logic signed [W-1:0] normal_y;
  logic signed [W-1:0] normal_z;
  logic                last_vertex;

  modport source (
    output valid, vertex_x, vertex_y, vertex_z, point_x, point_y, point_z,
           normal_x, normal_y, normal_z, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, vertex_x, vertex_y, vertex_z, point_x, point_y, point_z,
           normal_x, normal_y, normal_z, last_vertex,
    output ready
  );
endinterface

interface pip_result_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

// ----- rtl/core/pip_front.sv -----
// Projection, polygon state and edge setup for one registered vertex word.
module pip_front #(
  parameter int W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic signed [W-1:0] vx_i,
  input  logic signed [W-1:0] vy_i,
  input  logic signed [W-1:0] vz_i,
  input  logic signed [W-1:0] px_i,
  input  logic signed [W-1:0] py_i,
  input  logic signed [W-1:0] pz_i,
  input  logic signed [W-1:0] nx_i,
  input  logic signed [W-1:0] ny_i,
  input  logic signed [W-1:0] nz_i,
  input  logic                last_i,
  output pip_pkg::pip_flags_t flags_o,
  // edge from previous to current vertex
  output logic                cnt_a_o,
  output logic signed [W:0]   a_a_o,
  output logic signed [W:0]   b_a_o,
  output logic signed [W:0]   c_a_o,
  output logic signed [W:0]   d_a_o,
  // closing edge from current back to first vertex
  output logic                cnt_b_o,
  output logic signed [W:0]   a_b_o,
  output logic signed [W:0]   b_b_o,
  output logic signed [W:0]   c_b_o,
  output logic signed [W:0]   d_b_o
);

  localparam int DW = W + 1;

  logic                mid_q;
  pip_pkg::axis_e      axis_q;
  logic signed [W-1:0] probe_u_q, probe_v_q;
  logic signed [W-1:0] first_u_q, first_v_q;
  logic signed [W-1:0] prior_u_q, prior_v_q;

  logic                first;
  logic [W-1:0]        mag_x, mag_y, mag_z;
  pip_pkg::axis_e      pick, axis;
  logic signed [W-1:0] cu, cv, pu_new, pv_new, probe_u, probe_v, fu, fv;

  assign first = !mid_q;

  assign mag_x = nx_i[W-1] ? W'(-nx_i) : W'(nx_i);
  assign mag_y = ny_i[W-1] ? W'(-ny_i) : W'(ny_i);
  assign mag_z = nz_i[W-1] ? W'(-nz_i) : W'(nz_i);

  always_comb begin
    if (mag_x > mag_y) begin
      pick = (mag_y > mag_z || mag_x > mag_z) ? pip_pkg::AXIS_X : pip_pkg::AXIS_Z;
    end else begin
      pick = (mag_x > mag_z || mag_y > mag_z) ? pip_pkg::AXIS_Y : pip_pkg::AXIS_Z;
    end
  end

  assign axis = first ? pick : axis_q;

  // Keep the two coordinates that follow the dropped axis cyclically.
  always_comb begin
    case (axis)
      pip_pkg::AXIS_X: begin
        cu = vy_i;  cv = vz_i;
        pu_new = py_i;  pv_new = pz_i;
      end
      pip_pkg::AXIS_Y: begin
        cu = vz_i;  cv = vx_i;
        pu_new = pz_i;  pv_new = px_i;
      end
      default: begin
        cu = vx_i;  cv = vy_i;
        pu_new = px_i;  pv_new = py_i;
      end
    endcase
  end

  assign probe_u = first ? pu_new : probe_u_q;
  assign probe_v = first ? pv_new : probe_v_q;
  assign fu      = first ? cu : first_u_q;
  assign fv      = first ? cv : first_v_q;

  assign flags_o.first = first;
  assign flags_o.last  = last_i;

  // Edge A: current (cu, cv) against prior vertex.
  assign cnt_a_o = !first && (cv != prior_v_q) &&
                   ((probe_v >= cv && probe_v < prior_v_q) ||
                    (probe_v >= prior_v_q && probe_v < cv));
  assign a_a_o = DW'(probe_u) - DW'(prior_u_q);
  assign b_a_o = DW'(cu) - DW'(prior_u_q);
  assign c_a_o = DW'(probe_v) - DW'(prior_v_q);
  assign d_a_o = DW'(cv) - DW'(prior_v_q);

  // Edge B: first vertex against current vertex, only on the closing word.
  assign cnt_b_o = last_i && (fv != cv) &&
                   ((probe_v >= fv && probe_v < cv) ||
                    (probe_v >= cv && probe_v < fv));
  assign a_b_o = DW'(probe_u) - DW'(cu);
  assign b_b_o = DW'(fu) - DW'(cu);
  assign c_b_o = DW'(probe_v) - DW'(cv);
  assign d_b_o = DW'(fv) - DW'(cv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q     <= 1'b0;
      axis_q    <= pip_pkg::AXIS_X;
      probe_u_q <= '0;
      probe_v_q <= '0;
      first_u_q <= '0;
      first_v_q <= '0;
      prior_u_q <= '0;
      prior_v_q <= '0;
    end else if (adv_i) begin
      axis_q    <= axis;
      probe_u_q <= probe_u;
      probe_v_q <= probe_v;
      first_u_q <= fu;
      first_v_q <= fv;
      prior_u_q <= cu;
      prior_v_q <= cv;
      mid_q     <= !last_i;
    end
  end

endmodule

// ----- rtl/core/pip_edge.sv -----
// Exact crossing side test for one edge: operand register, products, compare.
module pip_edge #(
  parameter int W = 32
) (
  input  logic              clk_i,
  input  logic              ld2_i,
  input  logic              ld3_i,
  input  logic              cnt_i,
  input  logic signed [W:0] a_i,
  input  logic signed [W:0] b_i,
  input  logic signed [W:0] c_i,
  input  logic signed [W:0] d_i,
  output logic              toggle_o
);

  localparam int DW = W + 1;
  localparam int PW = 2 * DW;

  logic                 cnt2_q, cnt3_q, dneg3_q;
  logic signed [DW-1:0] a_q, b_q, c_q, d_q;
  logic signed [PW-1:0] lhs_d, rhs_d, lhs_q, rhs_q;

  assign lhs_d = PW'(a_q) * PW'(d_q);
  assign rhs_d = PW'(b_q) * PW'(c_q);

  always_ff @(posedge clk_i) begin
    if (ld2_i) begin
      cnt2_q <= cnt_i;
      a_q    <= a_i;
      b_q    <= b_i;
      c_q    <= c_i;
      d_q    <= d_i;
    end
    if (ld3_i) begin
      cnt3_q  <= cnt2_q;
      dneg3_q <= d_q[DW-1];
      lhs_q   <= lhs_d;
      rhs_q   <= rhs_d;
    end
  end

  // Crossing lies right of the point: compare sense flips with the sign of dv.
  assign toggle_o = cnt3_q && (dneg3_q ? (rhs_q < lhs_q) : (lhs_q < rhs_q));

endmodule

// ----- rtl/core/point_in_polygon_test.sv -----
// Point-in-polygon crossing test: pipeline control, parity and result register.
// Input register, setup, multiply and compare stages; the inside flag is then registered.
// Throughput: one vertex word per cycle unless a last word waits on a full result register.
// A result waiting on the output does not stall vertex words that produce none.
// Reset (rst_ni low, asynchronous) empties the pipeline and clears all polygon state.
module point_in_polygon_test #(
  parameter int COORD_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  pip_vertex_if.sink         vertex_i,
  pip_result_if.source       result_o
);

  localparam int W = COORD_WIDTH;

  // input register
  logic                s1_v_q;
  logic signed [W-1:0] vx_q, vy_q, vz_q, px_q, py_q, pz_q, nx_q, ny_q, nz_q;
  logic                last_q;

  logic                s2_v_q, s3_v_q;
  pip_pkg::pip_flags_t flags, flags2_q, flags3_q;

  logic parity_q, parity_d;
  logic out_v_q, out_res_q;

  logic go1, go2, go3, rdy1, rdy2, rdy3, out_free;

  logic              cnt_a, cnt_b, tog_a, tog_b;
  logic signed [W:0] a_a, b_a, c_a, d_a, a_b, b_b, c_b, d_b;

  assign out_free = !out_v_q || result_o.ready;
  assign go3  = s3_v_q && (!flags3_q.last || out_free);
  assign rdy3 = !s3_v_q || go3;
  assign go2  = s2_v_q && rdy3;
  assign rdy2 = !s2_v_q || go2;
  assign go1  = s1_v_q && rdy2;
  assign rdy1 = !s1_v_q || go1;

  assign vertex_i.ready = rdy1;

  always_ff @(posedge clk_i) begin
    if (vertex_i.valid && rdy1) begin
      vx_q   <= vertex_i.vertex_x;
      vy_q   <= vertex_i.vertex_y;
      vz_q   <= vertex_i.vertex_z;
      px_q   <= vertex_i.point_x;
      py_q   <= vertex_i.point_y;
      pz_q   <= vertex_i.point_z;
      nx_q   <= vertex_i.normal_x;
      ny_q   <= vertex_i.normal_y;
      nz_q   <= vertex_i.normal_z;
      last_q <= vertex_i.last_vertex;
    end
    if (go1) begin
      flags2_q <= flags;
    end
    if (go2) begin
      flags3_q <= flags2_q;
    end
  end

  pip_front #(.W(W)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (go1),
    .vx_i    (vx_q),
    .vy_i    (vy_q),
    .vz_i    (vz_q),
    .px_i    (px_q),
    .py_i    (py_q),
    .pz_i    (pz_q),
    .nx_i    (nx_q),
    .ny_i    (ny_q),
    .nz_i    (nz_q),
    .last_i  (last_q),
    .flags_o (flags),
    .cnt_a_o (cnt_a),
    .a_a_o   (a_a),
    .b_a_o   (b_a),
    .c_a_o   (c_a),
    .d_a_o   (d_a),
    .cnt_b_o (cnt_b),
    .a_b_o   (a_b),
    .b_b_o   (b_b),
    .c_b_o   (c_b),
    .d_b_o   (d_b)
  );

  pip_edge #(.W(W)) u_edge_a (
    .clk_i    (clk_i),
    .ld2_i    (go1),
    .ld3_i    (go2),
    .cnt_i    (cnt_a),
    .a_i      (a_a),
    .b_i      (b_a),
    .c_i      (c_a),
    .d_i      (d_a),
    .toggle_o (tog_a)
  );

  pip_edge #(.W(W)) u_edge_b (
    .clk_i    (clk_i),
    .ld2_i    (go1),
    .ld3_i    (go2),
    .cnt_i    (cnt_b),
    .a_i      (a_b),
    .b_i      (b_b),
    .c_i      (c_b),
    .d_i      (d_b),
    .toggle_o (tog_b)
  );

  // Restart the count on a polygon's first word.
  assign parity_d = (flags3_q.first ? 1'b0 : parity_q) ^ tog_a ^ tog_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      parity_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_v_q <= vertex_i.valid;
      end
      if (rdy2) begin
        s2_v_q <= go1;
      end
      if (rdy3) begin
        s3_v_q <= go2;
      end
      if (go3) begin
        parity_q <= flags3_q.last ? 1'b0 : parity_d;
      end
      if (go3 && flags3_q.last) begin
        out_v_q <= 1'b1;
      end else if (result_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go3 && flags3_q.last) begin
      out_res_q <= parity_d;
    end
  end

  assign result_o.valid      = out_v_q;
  assign result_o.inside_res = out_res_q;

endmodule
